### src/upq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types, codes and helpers for the unique priority queue. The entry
// store is a circular buffer, so logical positions are mapped to memory
// addresses relative to a head pointer.
// ----------------------------------------------------------------------------
package upq_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam int FUNC_W = 3;
    localparam int PRIO_W = 16;
    localparam int PAY_W  = 32;
    localparam int STAT_W = 3;
    localparam int OCC_W  = 5;

    localparam logic [FUNC_W-1:0] FN_ENQ  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOOK = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_count;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PAY_W-1:0]  payload;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_mem_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAY_W-1:0]  payload;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
        logic              empty;
    } t_result;

    // Memory address of logical position lidx, counted from the head. The sum
    // stays below twice the capacity, so one compare and subtract wraps it.
    function automatic t_addr phys_addr(input t_addr head, input t_count lidx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(lidx);
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return AW'(sum);
    endfunction

endpackage

### src/upq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upq_ram
// Simple dual-port memory: one write port, one read port with the read data
// registered, so read data appears in the cycle after the address.
// ----------------------------------------------------------------------------
module upq_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/upq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upq_ctrl
// Sequencer for the queue operations. It walks the entry memory one position
// per cycle to search and to shift, and hands each finished result over.
// ----------------------------------------------------------------------------
module upq_ctrl import upq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [PRIO_W-1:0] i_prio,
    input  logic [PAY_W-1:0]  i_payload,
    output t_mem_req          o_mem,
    input  t_entry            i_rdata,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output t_result           o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_TOP   = 3'd4;
    localparam logic [2:0] S_LOOK  = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0]        r_state, n_state;
    t_count            r_count, n_count;
    t_addr             r_head, n_head;
    t_count            r_idx, n_idx;
    t_count            r_pos, n_pos;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [PAY_W-1:0]  r_payload, n_payload;
    logic [STAT_W-1:0] r_status, n_status;
    logic [PAY_W-1:0]  r_rpay, n_rpay;
    logic [PRIO_W-1:0] r_rprio, n_rprio;

    t_count rd_lidx;
    t_count last_idx;
    t_count ins_pos;

    assign last_idx = r_count - t_count'(1);
    assign ins_pos  = (i_rdata.prio < r_prio) ? r_idx : r_count;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_func    = r_func;
        n_prio    = r_prio;
        n_payload = r_payload;
        n_status  = r_status;
        n_rpay    = r_rpay;
        n_rprio   = r_rprio;
        rd_lidx   = '0;
        o_mem.we    = 1'b0;
        o_mem.waddr = phys_addr(r_head, r_idx);
        o_mem.wdata = i_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func    = i_func;
                    n_prio    = i_prio;
                    n_payload = i_payload;
                    n_status  = ST_DONE;
                    n_rpay    = '0;
                    n_rprio   = '0;
                    n_idx     = '0;
                    case (i_func)
                        FN_ENQ: begin
                            if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_PUT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FN_DEQ, FN_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_TOP;
                            end
                        end
                        FN_LOOK: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_LOOK;
                            end
                        end
                        FN_CLR: begin
                            n_count = '0;
                            n_state = S_RES;
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_rdata.prio == r_prio) begin
                    n_status = ST_DUP;
                    n_state  = S_RES;
                end else if (i_rdata.prio < r_prio || r_idx == last_idx) begin
                    if (r_count >= t_count'(CAPACITY)) begin
                        n_status = ST_FULL;
                        n_state  = S_RES;
                    end else if (ins_pos == r_count) begin
                        n_pos   = ins_pos;
                        n_state = S_PUT;
                    end else begin
                        // Move entries down one place, starting at the tail.
                        n_pos   = ins_pos;
                        n_idx   = r_count;
                        rd_lidx = last_idx;
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_idx   = r_idx + t_count'(1);
                    rd_lidx = r_idx + t_count'(1);
                end
            end
            S_SHIFT: begin
                o_mem.we = 1'b1;
                if (r_idx - t_count'(1) == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_idx   = r_idx - t_count'(1);
                    rd_lidx = r_idx - t_count'(2);
                end
            end
            S_PUT: begin
                o_mem.we            = 1'b1;
                o_mem.waddr         = phys_addr(r_head, r_pos);
                o_mem.wdata.prio    = r_prio;
                o_mem.wdata.payload = r_payload;
                n_count             = r_count + t_count'(1);
                n_state             = S_RES;
            end
            S_TOP: begin
                n_rpay  = i_rdata.payload;
                n_rprio = i_rdata.prio;
                if (r_func == FN_DEQ) begin
                    n_head  = phys_addr(r_head, t_count'(1));
                    n_count = r_count - t_count'(1);
                end
                n_state = S_RES;
            end
            S_LOOK: begin
                if (i_rdata.payload == r_payload) begin
                    n_rprio = i_rdata.prio;
                    n_state = S_RES;
                end else if (r_idx == last_idx) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_RES;
                end else begin
                    n_idx   = r_idx + t_count'(1);
                    rd_lidx = r_idx + t_count'(1);
                end
            end
            S_RES: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_mem.raddr = phys_addr(r_head, rd_lidx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_func    <= n_func;
        r_prio    <= n_prio;
        r_payload <= n_payload;
        r_status  <= n_status;
        r_rpay    <= n_rpay;
        r_rprio   <= n_rprio;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_RES);
    assign o_res.status  = r_status;
    assign o_res.payload = r_rpay;
    assign o_res.prio    = r_rprio;
    assign o_res.occ     = OCC_W'(r_count);
    assign o_res.empty   = (r_count == '0);

endmodule

### src/unique_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_priority_queue
// Bounded priority queue with unique priorities, kept in descending order in
// a circular entry memory. One result beat comes back for every input beat.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Beat contents
//   -------   -------------------------   -----------------------------------
//   input     i_in_valid / o_in_ready     func, entry priority, entry payload
//   output    o_out_valid / i_out_ready   status, payload, priority,
//                                         occupancy, empty flag
//
// An item holds the sequencer while it walks the entry memory, whose single
// read port is read one position per cycle. Clear and unknown codes go straight
// to the result; dequeue and peek read the top entry; lookup walks until the
// payload matches or the tail is reached; enqueue searches, shifts and writes
// (the search stops at the insert position and the shift moves only the entries below it).
// Reset (synchronous, active low) empties the queue; the memory needs no
// clearing since only positions below the occupancy are ever read.
// The output register lets the next input beat be accepted while a result
// beat still waits for i_out_ready; a stalled output holds the sequencer
// only once its following result is also finished.
// ----------------------------------------------------------------------------
module unique_priority_queue import upq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [PRIO_W-1:0] i_entry_priority,
    input  logic [PAY_W-1:0]  i_entry_payload,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [PAY_W-1:0]  o_result_payload,
    output logic [PRIO_W-1:0] o_result_priority,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic              o_is_empty_flag
);

    t_mem_req mem_req;
    t_entry   mem_rdata;
    logic     res_valid;
    logic     res_take;
    t_result  res;

    logic     r_out_valid;
    t_result  r_out;

    // Entry memory: each word holds one priority and its payload tag.
    upq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer that searches, shifts and updates head and occupancy.
    upq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_func      (i_func),
        .i_prio      (i_entry_priority),
        .i_payload   (i_entry_payload),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // The output register takes a new result when it is empty or when its
    // current beat leaves in the same cycle.
    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_result_payload  = r_out.payload;
    assign o_result_priority = r_out.prio;
    assign o_occupancy       = r_out.occ;
    assign o_is_empty_flag   = r_out.empty;

endmodule
